// ===== hw/rtl/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // Number of continuation bytes that each lead class expects.
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendTwo   = 2'd1;
  localparam logic [PendW-1:0] PendThree = 2'd2;
  localparam logic [PendW-1:0] PendFour  = 2'd3;

  // Top two bits of a continuation byte.
  localparam logic [1:0] ContTag = 2'b10;

  // Sequence state that is carried from one byte to the next.
  typedef struct packed {
    logic [PendW-1:0] bytes_pending;
    logic [CpW-1:0]   gathered_bits;
  } seq_state_t;

  // Outcome of decoding one byte.
  typedef struct packed {
    seq_state_t     state_next;
    logic           emit;
    logic [CpW-1:0] code_point;
  } step_result_t;

endpackage : u8dec_pkg

`default_nettype wire

// ===== hw/rtl/u8dec_step.sv =====
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_step
  import u8dec_pkg::*;
(
  input  wire seq_state_t       state,
  input  wire logic [ByteW-1:0] data_byte,
  output step_result_t          result
);

  logic [PendW-1:0] pending_dec;
  logic [CpW-1:0]   shifted;

  // Continuation path: six more payload bits, one fewer byte expected.
  assign pending_dec = state.bytes_pending - PendTwo;
  assign shifted     = {state.gathered_bits[CpW-7:0], data_byte[5:0]};

  always_comb begin
    result            = '0;
    result.state_next = state;

    if (data_byte == '0) begin
      // End of string clears any partial sequence.
      result.state_next = '0;
    end else if (state.bytes_pending != PendNone && data_byte[7:6] == ContTag) begin
      if (pending_dec == PendNone) begin
        result.emit       = 1'b1;
        result.code_point = shifted;
        result.state_next = '0;
      end else begin
        result.state_next.bytes_pending = pending_dec;
        result.state_next.gathered_bits = shifted;
      end
    end else begin
      // Any partial sequence is dropped and the byte is taken as a lead.
      result.state_next = '0;
      case (data_byte) inside
        [8'h01:8'h7F]: begin
          result.emit       = 1'b1;
          result.code_point = {{(CpW-ByteW){1'b0}}, data_byte};
        end
        [8'hC0:8'hDF]: begin
          result.state_next.bytes_pending = PendTwo;
          result.state_next.gathered_bits = {{(CpW-5){1'b0}}, data_byte[4:0]};
        end
        [8'hE0:8'hEF]: begin
          result.state_next.bytes_pending = PendThree;
          result.state_next.gathered_bits = {{(CpW-4){1'b0}}, data_byte[3:0]};
        end
        [8'hF0:8'hF7]: begin
          result.state_next.bytes_pending = PendFour;
          result.state_next.gathered_bits = {{(CpW-3){1'b0}}, data_byte[2:0]};
        end
        default: begin
          // Stray continuation bytes and 0xF8-0xFF are dropped.
          result.state_next = '0;
        end
      endcase
    end
  end

endmodule : u8dec_step

`default_nettype wire

// ===== hw/rtl/utf8_byte_stream_decoder_core.sv =====
// Top level of the UTF-8 byte stream decoder: input register, decode, result register.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------
//   in      | sink      | in_valid / in_stall  | data_byte [7:0]
//   out     | source    | out_valid / out_stall| code_point [20:0]
//
// Each byte is registered in the input register and then decoded into the
// result register; a code point is written there once its last byte leaves
// the input register. One byte per cycle is sustained while out_stall is low;
// the rate is set by the single decode step between the two registers. Reset
// clears both valid flags and the sequence state. While out_stall holds a
// result, the input register keeps one more byte and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_core
  import u8dec_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CpW-1:0]        code_point
);

  logic             byte_valid;
  logic [ByteW-1:0] byte_reg;
  seq_state_t       seq_state;
  step_result_t     step;
  logic             out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = byte_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_reg <= data_byte;
    end
  end

  u8dec_step u_step (
    .state     (seq_state),
    .data_byte (byte_reg),
    .result    (step)
  );

  // Sequence state advances when the held byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= '0;
    end else if (byte_valid && out_free) begin
      seq_state <= step.state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= byte_valid && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && byte_valid && step.emit) begin
      code_point <= step.code_point;
    end
  end

endmodule : utf8_byte_stream_decoder_core

`default_nettype wire

// ===== tb/tb_utf8_byte_stream_decoder_core.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder core.
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder_core;
  import u8dec_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned NumDir        = 26;
  localparam int unsigned MaxReports    = 10;

  // How the expected result of a directed row is obtained.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_CODE,
    ROW_NONE
  } row_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    row_kind_e        kind;
    logic [CpW-1:0]   cp;
  } dir_row_t;

  // Directed rows: extremes, stray bytes, invalid leads, breaks and string ends.
  dir_row_t dir_rows [NumDir] = '{
    '{8'h00, ROW_NONE,    21'h000000},  // end of string right after reset
    '{8'h01, ROW_CODE,    21'h000001},
    '{8'h7F, ROW_CODE,    21'h00007F},
    '{8'h80, ROW_NONE,    21'h000000},  // stray continuation
    '{8'hC0, ROW_NONE,    21'h000000},
    '{8'h80, ROW_CODE,    21'h000000},  // smallest two-byte sequence
    '{8'hDF, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_CODE,    21'h0007FF},  // largest two-byte sequence
    '{8'hEF, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_CODE,    21'h00FFFF},  // largest three-byte sequence
    '{8'hF7, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_NONE,    21'h000000},
    '{8'hBF, ROW_CODE,    21'h1FFFFF},  // largest four-byte sequence
    '{8'hF8, ROW_PREDICT, 21'h000000},  // invalid lead
    '{8'hE2, ROW_PREDICT, 21'h000000},
    '{8'h82, ROW_PREDICT, 21'h000000},
    '{8'h41, ROW_PREDICT, 21'h000000},  // breaks the open sequence
    '{8'hF0, ROW_PREDICT, 21'h000000},
    '{8'h9F, ROW_PREDICT, 21'h000000},
    '{8'h00, ROW_NONE,    21'h000000},  // end of string inside a sequence
    '{8'h80, ROW_NONE,    21'h000000},  // now a stray continuation
    '{8'hC3, ROW_PREDICT, 21'h000000},
    '{8'hFF, ROW_PREDICT, 21'h000000},  // invalid lead drops the sequence
    '{8'hA9, ROW_PREDICT, 21'h000000}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CpW-1:0]   code_point;

  // Row kind and typed value that travel with the byte on the input channel.
  row_kind_e        cur_kind = ROW_PREDICT;
  logic [CpW-1:0]   cur_cp = '0;

  // Predictor state.
  logic [PendW-1:0] pend_st = PendNone;
  logic [CpW-1:0]   gath_st = '0;

  logic [CpW-1:0]   cp_expected [$];
  int unsigned      mismatches = 0;
  int unsigned      idle_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  bit               hold_req = 1'b0;
  int unsigned      hold_left = 0;

  utf8_byte_stream_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_point(code_point)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the predicted decoder state by one byte.
  task automatic decode_byte(input logic [ByteW-1:0] b, output logic emit,
                             output logic [CpW-1:0] cp);
    emit = 1'b0;
    cp   = '0;
    if (b == 8'h00) begin
      pend_st = PendNone;
      gath_st = '0;
    end else if (pend_st != PendNone && b[7:6] == ContTag) begin
      gath_st = {gath_st[CpW-7:0], b[5:0]};
      pend_st = pend_st - 1'b1;
      if (pend_st == PendNone) begin
        emit    = 1'b1;
        cp      = gath_st;
        gath_st = '0;
      end
    end else begin
      // Any open sequence is dropped and the byte is taken as a lead.
      pend_st = PendNone;
      gath_st = '0;
      if (!b[7]) begin
        emit = 1'b1;
        cp   = {{(CpW-ByteW){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        gath_st = {{(CpW-5){1'b0}}, b[4:0]};
        pend_st = PendTwo;
      end else if (b[7:4] == 4'b1110) begin
        gath_st = {{(CpW-4){1'b0}}, b[3:0]};
        pend_st = PendThree;
      end else if (b[7:3] == 5'b11110) begin
        gath_st = {{(CpW-3){1'b0}}, b[2:0]};
        pend_st = PendFour;
      end
    end
  endtask

  task automatic report(input string what, input logic [CpW-1:0] exp_cp,
                        input logic [CpW-1:0] act_cp);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("mismatch (%s): expected %06h, got %06h", what, exp_cp, act_cp);
    end
  endtask

  // Input beats feed the predictor; output beats are checked against it.
  always @(posedge clk) begin
    logic           emit_p;
    logic [CpW-1:0] cp_p;
    logic [CpW-1:0] cp_front;
    bit             moved;
    moved = 1'b0;
    if (rst) begin
      idle_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        decode_byte(data_byte, emit_p, cp_p);
        case (cur_kind)
          ROW_CODE: cp_expected.push_back(cur_cp);
          ROW_NONE: ;
          default: if (emit_p) cp_expected.push_back(cp_p);
        endcase
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (cp_expected.size() == 0) begin
          report("no result expected", '0, code_point);
        end else begin
          cp_front = cp_expected.pop_front();
          if (code_point !== cp_front) report("code_point", cp_front, code_point);
        end
      end
      if (moved) idle_count = 0;
      else idle_count++;
      if (idle_count >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_count, cp_expected.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one byte, with random idle cycles before it, until it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b, input row_kind_e k,
                           input logic [CpW-1:0] cp);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    cur_kind  <= k;
    cur_cp    <= cp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One random unit of text; mostly well-formed sequences with random payload.
  task automatic send_random_unit(inout int unsigned counted);
    int unsigned r;
    int unsigned len;
    int unsigned conts;
    logic [ByteW-1:0] lead;
    r = $urandom_range(99);
    if (r < 35) begin
      send_byte(8'($urandom_range(127, 1)), ROW_PREDICT, '0);
      counted++;
    end else if (r < 90 && r >= 42) begin
      len = $urandom_range(4, 2);
      case (len)
        2: lead = {3'b110, 5'($urandom_range(31))};
        3: lead = {4'b1110, 4'($urandom_range(15))};
        default: lead = {5'b11110, 3'($urandom_range(7))};
      endcase
      // Some sequences are cut short so that the next unit breaks them.
      conts = (r >= 82) ? $urandom_range(len - 2) : len - 1;
      send_byte(lead, ROW_PREDICT, '0);
      counted++;
      for (int unsigned i = 0; i < conts; i++) begin
        send_byte({2'b10, 6'($urandom_range(63))}, ROW_PREDICT, '0);
        counted++;
      end
    end else if (r < 42) begin
      send_byte(8'h00, ROW_PREDICT, '0);
      counted++;
    end else begin
      // Noise: any byte at all, often ignored by the block.
      send_byte(8'($urandom_range(255)), ROW_PREDICT, '0);
      counted++;
    end
  endtask

  // Hold the input idle until every expected code point has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cp_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Main sequence: reset, then three phases of random text with different idle and stall rates, directed rows first.
  initial begin
    int unsigned counted;
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    send_pct = '{10, 86, 0};
    recv_pct = '{86, 10, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) begin
        for (int i = 0; i < NumDir; i++) begin
          send_byte(dir_rows[i].data, dir_rows[i].kind, dir_rows[i].cp);
        end
      end
      // With no idling, a long receiver hold-off lets the block back up.
      if (p == 2) hold_req = 1'b1;
      counted = 0;
      while (counted < PhaseItems) send_random_unit(counted);
      wait_drained();
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && cp_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches,
               cp_expected.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_step.sv
hw/rtl/utf8_byte_stream_decoder_core.sv
tb/tb_utf8_byte_stream_decoder_core.sv
